// ===== rtl/hdmd_pkg.sv =====
// hdmd_pkg: shared constants and types of the histogram difference motion detector
// no dependencies; used by every file of the block but hdmd_ram
package hdmd_pkg;

    // field widths
    localparam int SAMPLE_W  = 8;
    localparam int BIN_VAL_W = 21;
    localparam int SUM_W     = 23;
    localparam int THR_W     = 16;

    // defaults for the top level parameters
    localparam int DEF_BIN_COUNT        = 64;
    localparam int DEF_MAX_FRAME_PIXELS = 2097152;

    // saturation limits and register reset
    localparam logic [BIN_VAL_W-1:0] BIN_MAX = {BIN_VAL_W{1'b1}};
    localparam logic [SUM_W-1:0]     SUM_MAX = 23'd4194304;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET = 16'd4260;

    // fraction bits of the Q0.16 threshold
    localparam int Q16_SHIFT = 16;

    // control from the sequencer to the difference unit
    typedef struct packed {
        logic sum_clear;
        logic acc_en;
        logic mul_en;
    } judge_ctrl_t;

endpackage

// ===== rtl/hdmd_stream_if.sv =====
// hdmd_stream_if: valid/ready channels for pixel input and result output
// depends on hdmd_pkg for the payload widths
interface hdmd_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [hdmd_pkg::SAMPLE_W-1:0] red_sample;
    logic                          frame_last;

    modport source (output valid, output red_sample, output frame_last, input ready);
    modport sink (input valid, input red_sample, input frame_last, output ready);
endinterface

interface hdmd_result_if;
    logic                       valid;
    logic                       ready;
    logic [hdmd_pkg::SUM_W-1:0] difference_sum;
    logic                       motion_flag;

    modport source (output valid, output difference_sum, output motion_flag, input ready);
    modport sink (input valid, input difference_sum, input motion_flag, output ready);
endinterface

// ===== rtl/histogram_difference_motion_detect.sv =====
// Histogram difference motion detector, red channel, two ping-pong bin rams.
// Throughput: one pixel per cycle inside a frame (bin read-modify-write with forwarding).
// After a frame's last pixel, ready stays low through the drain, the sweep of both rams bin by bin,
// the tail, multiply and compare states (longer while an earlier result waits), and the result is
// valid together with the return of ready.
// After the first frame's last pixel ready is low only in the drain state and no result comes.
// Reset: asynchronous, then a clearing pass over every bin of both rams with ready low.
module histogram_difference_motion_detect #(
    parameter int BIN_COUNT        = hdmd_pkg::DEF_BIN_COUNT,
    parameter int MAX_FRAME_PIXELS = hdmd_pkg::DEF_MAX_FRAME_PIXELS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    hdmd_pixel_if.sink                 pixel_in,
    hdmd_result_if.source              result_out,
    input  logic                       motion_threshold_wr_en,
    input  logic [hdmd_pkg::THR_W-1:0] motion_threshold_wr_data
);

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_PIXELS);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_RUN   = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_SWEEP = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_CMP   = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [BIN_W-1:0]           cnt_reg, cnt_next;
    logic                       sw_vld_reg, sw_vld_next;
    logic [BIN_W-1:0]           sw_addr_reg, sw_addr_next;
    logic                       bank_sel_reg, bank_sel_next;
    logic                       have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]           pix_cnt_reg, pix_cnt_next;
    logic [hdmd_pkg::THR_W-1:0] thr_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [hdmd_pkg::SUM_W-1:0] out_sum_reg, out_sum_next;
    logic                       out_flag_reg, out_flag_next;

    logic                       in_acc;
    logic                       out_free;
    logic                       clearing;
    hdmd_pkg::judge_ctrl_t      jctl;

    logic [BIN_W-1:0]               hist_raddr;
    logic                           hist_we;
    logic [BIN_W-1:0]               hist_waddr;
    logic [hdmd_pkg::BIN_VAL_W-1:0] hist_wdata;
    logic [BIN_W-1:0]               ram_raddr;
    logic                           ram_we    [2];
    logic [BIN_W-1:0]               ram_waddr [2];
    logic [hdmd_pkg::BIN_VAL_W-1:0] ram_wdata [2];
    logic [hdmd_pkg::BIN_VAL_W-1:0] ram_rdata [2];
    logic [hdmd_pkg::BIN_VAL_W-1:0] cur_rdata;
    logic [hdmd_pkg::BIN_VAL_W-1:0] prev_rdata;
    logic [hdmd_pkg::SUM_W-1:0]     judge_sum;
    logic                           judge_flag;

    // handshake
    assign pixel_in.ready = (state_reg == ST_RUN);
    assign in_acc         = pixel_in.valid && pixel_in.ready;
    assign out_free       = !out_valid_reg || result_out.ready;
    assign clearing       = (state_reg == ST_CLEAR);

    assign result_out.valid          = out_valid_reg;
    assign result_out.difference_sum = out_sum_reg;
    assign result_out.motion_flag    = out_flag_reg;

    // bank selection
    assign cur_rdata  = bank_sel_reg ? ram_rdata[1] : ram_rdata[0];
    assign prev_rdata = bank_sel_reg ? ram_rdata[0] : ram_rdata[1];
    assign ram_raddr  = (state_reg == ST_SWEEP) ? cnt_reg : hist_raddr;

    // ram write muxing: clear pass, histogram update on current, sweep zeroing on previous
    for (genvar k = 0; k < 2; k++)
    begin : g_bank
        logic is_cur;

        assign is_cur       = (bank_sel_reg == 1'(k));
        assign ram_we[k]    = clearing || (hist_we && is_cur) || (sw_vld_reg && !is_cur);
        assign ram_waddr[k] = clearing ? cnt_reg : (sw_vld_reg ? sw_addr_reg : hist_waddr);
        assign ram_wdata[k] = (clearing || sw_vld_reg) ? '0 : hist_wdata;

        hdmd_ram #(
            .WIDTH (hdmd_pkg::BIN_VAL_W),
            .DEPTH (BIN_COUNT)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[k]),
            .waddr (ram_waddr[k]),
            .wdata (ram_wdata[k]),
            .raddr (ram_raddr),
            .rdata (ram_rdata[k])
        );
    end

    // per-pixel bin update
    hdmd_hist_update #(
        .BIN_COUNT (BIN_COUNT)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_acc),
        .sample (pixel_in.red_sample),
        .rdata  (cur_rdata),
        .raddr  (hist_raddr),
        .we     (hist_we),
        .waddr  (hist_waddr),
        .wdata  (hist_wdata)
    );

    // frame-end difference and decision
    hdmd_diff_judge #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_judge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (jctl),
        .cur_bin     (cur_rdata),
        .prev_bin    (prev_rdata),
        .threshold   (thr_reg),
        .pixel_count (pix_cnt_reg),
        .sum         (judge_sum),
        .flag        (judge_flag)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sw_vld_next    = 1'b0;
        sw_addr_next   = sw_addr_reg;
        bank_sel_next  = bank_sel_reg;
        have_prev_next = have_prev_reg;
        pix_cnt_next   = pix_cnt_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_sum_next   = out_sum_reg;
        out_flag_next  = out_flag_reg;
        jctl           = '0;
        jctl.acc_en    = sw_vld_reg;

        if (in_acc && (pix_cnt_reg < CNT_MAX))
        begin
            pix_cnt_next = pix_cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + BIN_W'(1);
                if (cnt_reg == BIN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_acc && pixel_in.frame_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (have_prev_reg)
                begin
                    cnt_next       = '0;
                    jctl.sum_clear = 1'b1;
                    state_next     = ST_SWEEP;
                end
                else
                begin
                    bank_sel_next  = !bank_sel_reg;
                    have_prev_next = 1'b1;
                    pix_cnt_next   = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_SWEEP:
            begin
                sw_vld_next  = 1'b1;
                sw_addr_next = cnt_reg;
                cnt_next     = cnt_reg + BIN_W'(1);
                if (cnt_reg == BIN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                jctl.mul_en = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = judge_sum;
                    out_flag_next  = judge_flag;
                    bank_sel_next  = !bank_sel_reg;
                    pix_cnt_next   = '0;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            sw_vld_reg    <= 1'b0;
            bank_sel_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            pix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= hdmd_pkg::THRESHOLD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sw_vld_reg    <= sw_vld_next;
            bank_sel_reg  <= bank_sel_next;
            have_prev_reg <= have_prev_next;
            pix_cnt_reg   <= pix_cnt_next;
            out_valid_reg <= out_valid_next;
            if (motion_threshold_wr_en)
            begin
                thr_reg <= motion_threshold_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sw_addr_reg  <= sw_addr_next;
        out_sum_reg  <= out_sum_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

// ===== rtl/hdmd_ram.sv =====
// hdmd_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module hdmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hdmd_hist_update.sv =====
// hdmd_hist_update: bin lookup and read-modify-write of the current histogram bank
// depends on hdmd_pkg; drives the bin ram through the top level
module hdmd_hist_update #(
    parameter int BIN_COUNT = hdmd_pkg::DEF_BIN_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [hdmd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [hdmd_pkg::BIN_VAL_W-1:0] rdata,
    output logic [$clog2(BIN_COUNT)-1:0]   raddr,
    output logic                           we,
    output logic [$clog2(BIN_COUNT)-1:0]   waddr,
    output logic [hdmd_pkg::BIN_VAL_W-1:0] wdata
);

    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int PROD_W = hdmd_pkg::SAMPLE_W + 9;

    logic [PROD_W-1:0]              bin_prod;
    logic                           s1_vld_reg;
    logic [BIN_W-1:0]               s1_bin_reg;
    logic                           fwd_vld_reg;
    logic [BIN_W-1:0]               fwd_bin_reg;
    logic [hdmd_pkg::BIN_VAL_W-1:0] fwd_val_reg;
    logic [hdmd_pkg::BIN_VAL_W-1:0] old_val;
    logic [hdmd_pkg::BIN_VAL_W-1:0] new_val;

    // bin = sample * BIN_COUNT / 256, always below BIN_COUNT
    assign bin_prod = PROD_W'(sample) * PROD_W'(BIN_COUNT);
    assign raddr    = bin_prod[hdmd_pkg::SAMPLE_W +: BIN_W];

    // forward the value written at the edge where this read was sampled
    assign old_val = (fwd_vld_reg && (fwd_bin_reg == s1_bin_reg)) ? fwd_val_reg : rdata;
    assign new_val = (old_val == hdmd_pkg::BIN_MAX) ? old_val
                                                    : old_val + hdmd_pkg::BIN_VAL_W'(1);

    assign we    = s1_vld_reg;
    assign waddr = s1_bin_reg;
    assign wdata = new_val;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= accept;
            fwd_vld_reg <= s1_vld_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_bin_reg  <= raddr;
        fwd_bin_reg <= s1_bin_reg;
        fwd_val_reg <= new_val;
    end

endmodule

// ===== rtl/hdmd_diff_judge.sv =====
// hdmd_diff_judge: absolute bin difference accumulation and the motion comparison
// depends on hdmd_pkg; fed by the sweep of both bin banks
module hdmd_diff_judge #(
    parameter int MAX_FRAME_PIXELS = hdmd_pkg::DEF_MAX_FRAME_PIXELS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hdmd_pkg::judge_ctrl_t                 ctrl,
    input  logic [hdmd_pkg::BIN_VAL_W-1:0]        cur_bin,
    input  logic [hdmd_pkg::BIN_VAL_W-1:0]        prev_bin,
    input  logic [hdmd_pkg::THR_W-1:0]            threshold,
    input  logic [$clog2(MAX_FRAME_PIXELS+1)-1:0] pixel_count,
    output logic [hdmd_pkg::SUM_W-1:0]            sum,
    output logic                                  flag
);

    localparam int CNT_W   = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int PROD_W  = hdmd_pkg::THR_W + CNT_W;
    localparam int SUM3_W  = hdmd_pkg::SUM_W + 2;
    localparam int LHS_W   = SUM3_W + hdmd_pkg::Q16_SHIFT;
    localparam int CMP_W   = (LHS_W > PROD_W) ? LHS_W : PROD_W;

    logic [hdmd_pkg::BIN_VAL_W-1:0] diff;
    logic [hdmd_pkg::SUM_W:0]       sum_wide;
    logic [hdmd_pkg::SUM_W-1:0]     sum_reg;
    logic [hdmd_pkg::SUM_W-1:0]     sum_next;
    logic [SUM3_W-1:0]              sum3_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic [LHS_W-1:0]               lhs;

    // absolute difference and saturating accumulate
    assign diff     = (cur_bin > prev_bin) ? cur_bin - prev_bin : prev_bin - cur_bin;
    assign sum_wide = {1'b0, sum_reg} + (hdmd_pkg::SUM_W + 1)'(diff);
    assign sum_next = (sum_wide > (hdmd_pkg::SUM_W + 1)'(hdmd_pkg::SUM_MAX))
                    ? hdmd_pkg::SUM_MAX : sum_wide[hdmd_pkg::SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // scale both sides, one multiply per cycle while mul_en is set
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            sum3_reg <= SUM3_W'(sum_reg) + {1'b0, sum_reg, 1'b0};
            prod_reg <= PROD_W'(threshold) * PROD_W'(pixel_count);
        end
    end

    // 3 * sum * 65536 against threshold * pixel_count
    assign lhs  = {sum3_reg, {hdmd_pkg::Q16_SHIFT{1'b0}}};
    assign flag = CMP_W'(lhs) > CMP_W'(prod_reg);
    assign sum  = sum_reg;

endmodule

// ===== rtl/hdmd_checker.sv =====
// hdmd_checker: port-level assertions for the motion detector, bound to the top level
// depends on hdmd_pkg and histogram_difference_motion_detect
module hdmd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [hdmd_pkg::SUM_W-1:0] out_sum,
    input logic                       out_flag
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sum) && $stable(out_flag))
        else $error("result payload changed while stalled");

    // a frame end closes the input for the difference pass
    a_frame_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input accepted right after a frame end");

    // motion needs a nonzero difference
    a_flag_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_flag |-> out_sum != '0)
        else $error("motion flagged with zero difference");

    // difference sum is saturated
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_sum <= hdmd_pkg::SUM_MAX)
        else $error("difference sum above its limit");

endmodule

bind histogram_difference_motion_detect hdmd_checker u_hdmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .in_last   (pixel_in.frame_last),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_sum   (result_out.difference_sum),
    .out_flag  (result_out.motion_flag)
);

// ===== bench/hdmd_motion_checker.sv =====
// hdmd_motion_checker: watches the pixel, result and threshold ports, keeps its own
// frame histograms and checks every result transaction against the expected verdict
// depends on hdmd_pkg and the channel interfaces in hdmd_stream_if
module hdmd_motion_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    hdmd_pixel_if                      pixel_mon,
    hdmd_result_if                     result_mon,
    input  logic                       threshold_wr_en,
    input  logic [hdmd_pkg::THR_W-1:0] threshold_wr_data,
    output int                         mismatch_count,
    output int                         outstanding
);

    localparam int BINS        = hdmd_pkg::DEF_BIN_COUNT;
    localparam int PIXEL_LIMIT = hdmd_pkg::DEF_MAX_FRAME_PIXELS;
    localparam int DIFF_WEIGHT = 3;

    typedef struct packed {
        logic [hdmd_pkg::SUM_W-1:0] difference_sum;
        logic                       motion_flag;
    } motion_verdict_t;

    // mirrored state of the detector
    logic [hdmd_pkg::BIN_VAL_W-1:0] frame_hist [BINS];
    logic [hdmd_pkg::BIN_VAL_W-1:0] prior_hist [BINS];
    logic [21:0]                    frame_pixels;
    logic                           have_prior;
    logic [hdmd_pkg::THR_W-1:0]     threshold;
    motion_verdict_t                expected_verdicts [$];
    int                             errors;

    // sum of bin differences and the scaled threshold comparison
    function automatic motion_verdict_t judge_frame();
        logic [63:0]     total;
        logic [63:0]     lhs;
        logic [63:0]     rhs;
        motion_verdict_t verdict;
        total = '0;
        for (int i = 0; i < BINS; i++)
        begin
            if (frame_hist[i] > prior_hist[i])
                total += 64'(frame_hist[i] - prior_hist[i]);
            else
                total += 64'(prior_hist[i] - frame_hist[i]);
        end
        if (total > 64'(hdmd_pkg::SUM_MAX))
            total = 64'(hdmd_pkg::SUM_MAX);
        lhs = (total * DIFF_WEIGHT) << hdmd_pkg::Q16_SHIFT;
        rhs = 64'(threshold) * 64'(frame_pixels);
        verdict.difference_sum = total[hdmd_pkg::SUM_W-1:0];
        verdict.motion_flag    = (lhs > rhs);
        return verdict;
    endfunction

    // one pixel into the histogram, frame close on the last one
    task automatic count_pixel(input logic [hdmd_pkg::SAMPLE_W-1:0] sample, input logic last);
        int bin;
        bin = (int'(sample) * BINS) >> hdmd_pkg::SAMPLE_W;
        if (bin >= BINS)
            bin = BINS - 1;
        if (frame_hist[bin] != hdmd_pkg::BIN_MAX)
            frame_hist[bin] = frame_hist[bin] + 1'b1;
        if (frame_pixels < PIXEL_LIMIT)
            frame_pixels = frame_pixels + 1'b1;
        if (last)
        begin
            if (have_prior)
                expected_verdicts.push_back(judge_frame());
            prior_hist = frame_hist;
            for (int i = 0; i < BINS; i++)
                frame_hist[i] = '0;
            frame_pixels = '0;
            have_prior   = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        motion_verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                frame_hist[i] = '0;
                prior_hist[i] = '0;
            end
            frame_pixels = '0;
            have_prior   = 1'b0;
            threshold    = hdmd_pkg::THRESHOLD_RESET;
            expected_verdicts.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // pixel transaction
            if (pixel_mon.valid && pixel_mon.ready)
                count_pixel(pixel_mon.red_sample, pixel_mon.frame_last);

            // result transaction
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result: difference_sum %0d motion_flag %0d",
                           result_mon.difference_sum, result_mon.motion_flag);
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result_mon.difference_sum !== want.difference_sum)
                    begin
                        $error("difference_sum: expected %0d, actual %0d",
                               want.difference_sum, result_mon.difference_sum);
                        errors++;
                    end
                    if (result_mon.motion_flag !== want.motion_flag)
                    begin
                        $error("motion_flag: expected %0d, actual %0d",
                               want.motion_flag, result_mon.motion_flag);
                        errors++;
                    end
                end
            end

            // threshold register write
            if (threshold_wr_en)
                threshold = threshold_wr_data;

            mismatch_count <= errors;
            outstanding    <= expected_verdicts.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// testbench: clock, reset and frame stimulus for histogram_difference_motion_detect
// depends on hdmd_pkg, hdmd_stream_if, the block and hdmd_motion_checker
module testbench;

    localparam int BINS        = hdmd_pkg::DEF_BIN_COUNT;
    localparam int ITEM_TARGET = 1750;
    localparam int QUIET       = BINS + 16;
    localparam int STALL_LIMIT = 2000;

    typedef enum int {
        FRAME_NOISE,
        FRAME_REPEAT,
        FRAME_NUDGE,
        FRAME_NARROW,
        FRAME_EXTREME
    } frame_style_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       thr_wr_en;
    logic [hdmd_pkg::THR_W-1:0] thr_wr_data;
    int                         mismatch_count;
    int                         outstanding;
    int                         gap_odds;
    int                         stall_odds;
    int                         items_sent;
    int                         idle_cycles;
    logic [7:0]                 prior_frame [$];

    hdmd_pixel_if  pix ();
    hdmd_result_if res ();

    histogram_difference_motion_detect dut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .pixel_in                 (pix),
        .result_out               (res),
        .motion_threshold_wr_en   (thr_wr_en),
        .motion_threshold_wr_data (thr_wr_data)
    );

    hdmd_motion_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixel_mon         (pix),
        .result_mon        (res),
        .threshold_wr_en   (thr_wr_en),
        .threshold_wr_data (thr_wr_data),
        .mismatch_count    (mismatch_count),
        .outstanding       (outstanding)
    );

    // clock
    always #5 clk = ~clk;

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result sink with random stall bursts
    initial
    begin : result_drain
        int stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall = $urandom_range(1, 11);
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    // one pixel transaction, with an optional gap before it
    task automatic send_pixel(input logic [7:0] sample, input logic last);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 11);
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid      <= 1'b1;
        pix.red_sample <= sample;
        pix.frame_last <= last;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    // whole frame, last pixel flagged
    task automatic play_frame(input logic [7:0] samples [$]);
        for (int k = 0; k < samples.size(); k++)
            send_pixel(samples[k], k == samples.size() - 1);
        prior_frame = samples;
        items_sent += samples.size();
    endtask

    // mostly short frames, a few long ones
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 39);
        if (roll == 0)
            return $urandom_range(200, 600);
        if (roll < 6)
            return $urandom_range(25, 100);
        return $urandom_range(1, 24);
    endfunction

    // build a frame whose histogram relates to the previous one in a chosen way
    task automatic send_frame(input frame_style_t style);
        logic [7:0] fresh [$];
        logic [7:0] centre;
        logic [7:0] swap;
        int         length;
        int         pick;
        length = pick_length();
        centre = 8'($urandom_range(0, 255));
        if ((style == FRAME_REPEAT || style == FRAME_NUDGE) && prior_frame.size() != 0)
        begin
            fresh = prior_frame;
            // same histogram in a new order
            for (int k = fresh.size() - 1; k > 0; k--)
            begin
                pick        = $urandom_range(0, k);
                swap        = fresh[k];
                fresh[k]    = fresh[pick];
                fresh[pick] = swap;
            end
            if (style == FRAME_NUDGE)
            begin
                repeat ($urandom_range(1, 3))
                    fresh[$urandom_range(0, fresh.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        else
        begin
            for (int k = 0; k < length; k++)
            begin
                case (style)
                    FRAME_NARROW:
                        fresh.push_back({centre[7:2], 2'($urandom_range(0, 3))});
                    FRAME_EXTREME:
                        fresh.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
                    default:
                        fresh.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        play_frame(fresh);
    endtask

    // drain all expected results, then let the block finish its sweep
    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic load_threshold(input logic [hdmd_pkg::THR_W-1:0] level);
        thr_wr_en   <= 1'b1;
        thr_wr_data <= level;
        @(posedge clk);
        thr_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [hdmd_pkg::THR_W-1:0] levels [6];
        logic [hdmd_pkg::THR_W-1:0] level;
        logic                       quiet_tail;
        int                         phase;
        int                         phase_start;
        levels = '{16'd0, 16'd65535, hdmd_pkg::THRESHOLD_RESET, 16'd1, 16'd65534, 16'd4260};
        rst_n          = 1'b0;
        pix.valid      = 1'b0;
        pix.red_sample = '0;
        pix.frame_last = 1'b0;
        thr_wr_en      = 1'b0;
        thr_wr_data    = '0;
        gap_odds       = 0;
        stall_odds     = 0;
        items_sent     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first frame with bin edges, single-pixel frames, equal histograms
        play_frame('{8'd0, 8'd3, 8'd4, 8'd251, 8'd252, 8'd255});
        play_frame('{8'd128});
        play_frame('{8'd128});
        play_frame('{8'd255, 8'd255, 8'd0, 8'd0});
        settle();
        load_threshold(16'd0);
        play_frame('{8'd64, 8'd64});
        play_frame('{8'd65, 8'd66});
        settle();
        load_threshold(16'd65535);
        play_frame('{8'd200});
        play_frame('{8'd201, 8'd127, 8'd1});

        // random phases, each under its own threshold
        items_sent = 0;
        phase      = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            if (phase < 6)
                level = levels[phase];
            else if ($urandom_range(0, 1) == 1)
                level = 16'($urandom_range(0, 65535));
            else
                level = 16'($urandom_range(0, 9000));
            load_threshold(level);
            quiet_tail = items_sent > ITEM_TARGET * 85 / 100;
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 2;
                default: gap_odds = 6;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 3;
                default: stall_odds = 8;
            endcase
            if (quiet_tail)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < 140 && items_sent < ITEM_TARGET)
                send_frame(frame_style_t'($urandom_range(0, 4)));
            phase++;
        end

        // drain and verdict
        pix.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hdmd_pkg.sv
rtl/hdmd_stream_if.sv
rtl/hdmd_ram.sv
rtl/hdmd_hist_update.sv
rtl/hdmd_diff_judge.sv
rtl/histogram_difference_motion_detect.sv
rtl/hdmd_checker.sv
bench/hdmd_motion_checker.sv
bench/testbench.sv
